// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define MIE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Implication whose consequent is checked in the next cycle.
`define MIE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/mie_pkg.sv =====
// ---------------------------------------------------------------------------
// mie_pkg
// Shared widths, types and states of the modular inverse block.
// ---------------------------------------------------------------------------
package mie_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_LOAD,
      ST_STEP,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic             start;
      logic [WIDTH-1:0] numer;
      logic [WIDTH-1:0] denom;
      logic [WIDTH-1:0] mult;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [WIDTH-1:0] rem;
      logic [WIDTH-1:0] acc;
   } div_rsp_type;

endpackage

// ===== src/mie_divstep.sv =====
// ---------------------------------------------------------------------------
// mie_divstep
// Bit-serial restoring divider, one quotient bit per cycle. Each quotient bit
// is folded into acc = 2*acc + qbit*mult, so acc ends as quotient*mult.
// ---------------------------------------------------------------------------
module mie_divstep
   import mie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [WIDTH-1:0] num_ff, num_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [WIDTH-1:0] mul_ff, mul_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, num_ff[WIDTH-1]};
      ge      = trial >= {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      mul_in  = mul_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.numer;
         den_in  = req.denom;
         mul_in  = req.mult;
         rem_in  = '0;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[WIDTH-2:0], 1'b0};
         rem_in = ge ? WIDTH'(trial - {1'b0, den_ff}) : trial[WIDTH-1:0];
         acc_in = {acc_ff[WIDTH-2:0], 1'b0} + (ge ? mul_ff : '0);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      mul_ff <= mul_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;
   assign rsp.acc  = acc_ff;

`include "assert_macros.svh"
   `MIE_ASSERT_IMP(a_rem_below_den, done_ff, rem_ff < den_ff)
   `MIE_ASSERT_NEXT(a_done_after_busy, busy_ff && !req.start && cnt_ff == CNT_W'(WIDTH - 1),
      done_ff && !busy_ff)

endmodule

// ===== src/modular_inverse_ext_euclid.sv =====
// ---------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse by the extended Euclidean algorithm on a bit-serial divider.
// ---------------------------------------------------------------------------
//   channel  ports                          beat
//   req      req_value, req_modulus         one pair to invert
//   rsp      rsp_inverse, rsp_no_inverse    one result per req beat
//
// One item at a time. The reduction and each Euclid step run in the shared
// bit-serial divider; up to about 1.44*WIDTH steps. Reset is synchronous and
// clears all control state. A stalled result is held in the output register;
// the next request is taken meanwhile but its result waits in the final state
// until the output register frees.
// ---------------------------------------------------------------------------
module modular_inverse_ext_euclid
   import mie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic [31:0] req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_inverse,
   output logic        rsp_no_inverse
);

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] r0_ff, r0_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [WIDTH-1:0] x0_ff, x0_in;
   logic [WIDTH-1:0] x1_ff, x1_in;
   logic             par_ff, par_in;
   logic             fail_ff, fail_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_inv_ff, rsp_inv_in;
   logic             rsp_ni_ff, rsp_ni_in;
   div_req_type      dreq;
   div_rsp_type      drsp;
   logic [WIDTH-1:0] x0m, tval;
   logic             ok;

   mie_divstep u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_comb begin
      x0m  = (x0_ff >= m_ff) ? x0_ff - m_ff : x0_ff;
      tval = par_ff ? x0m : ((x0m == '0) ? '0 : m_ff - x0m);
      ok   = !fail_ff && r0_ff == WIDTH'(1) && tval != '0;
   end

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      par_in       = par_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_inv_in   = rsp_inv_ff;
      rsp_ni_in    = rsp_ni_ff;
      dreq.start   = 1'b0;
      dreq.numer   = r0_ff;
      dreq.denom   = r1_ff;
      dreq.mult    = x1_ff;
      req_stall    = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               m_in    = WIDTH'(req_modulus);
               fail_in = 1'b0;
               if (WIDTH'(req_modulus) < WIDTH'(2)) begin
                  fail_in  = 1'b1;
                  state_in = ST_FINAL;
               end else begin
                  dreq.start = 1'b1;
                  dreq.numer = WIDTH'(req_value);
                  dreq.denom = WIDTH'(req_modulus);
                  dreq.mult  = '0;
                  state_in   = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (drsp.done) begin
               r0_in  = m_ff;
               r1_in  = drsp.rem;
               x0_in  = '0;
               x1_in  = WIDTH'(1);
               par_in = 1'b0;
               if (drsp.rem == '0) begin
                  fail_in  = 1'b1;
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            dreq.start = 1'b1;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            if (drsp.done) begin
               r0_in  = r1_ff;
               r1_in  = drsp.rem;
               x0_in  = x1_ff;
               x1_in  = drsp.acc + x0_ff;
               par_in = !par_ff;
               state_in = (drsp.rem == '0) ? ST_FINAL : ST_LOAD;
            end
         end
         ST_FINAL: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_inv_in   = ok ? 32'(tval) : '0;
               rsp_ni_in    = !ok;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fail_ff      <= 1'b0;
         par_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fail_ff      <= fail_in;
         par_ff       <= par_in;
      end
      m_ff       <= m_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      rsp_inv_ff <= rsp_inv_in;
      rsp_ni_ff  <= rsp_ni_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inverse    = rsp_inv_ff;
   assign rsp_no_inverse = rsp_ni_ff;

`include "assert_macros.svh"
   `MIE_ASSERT_IMP(a_flag_zero, rsp_valid_ff && rsp_ni_ff, rsp_inv_ff == '0)
   `MIE_ASSERT_IMP(a_inv_nonzero, rsp_valid_ff && !rsp_ni_ff, rsp_inv_ff != '0)

endmodule

// ===== tb/tb_modular_inverse_ext_euclid.sv =====
// ---------------------------------------------------------------------------
// tb_modular_inverse_ext_euclid
// Drives value/modulus pairs through the modular inverse block, predicts each
// result with an extended Euclid computed in the testbench and checks every
// rsp beat in order. Directed corner pairs first, then random pairs with
// random idling on both sides and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_modular_inverse_ext_euclid;
   timeunit 1ns;
   timeprecision 1ps;

   import mie_pkg::*;

   localparam int N_RANDOM = 1330;

   typedef struct {
      logic [31:0] inverse;
      logic        no_inverse;
   } inv_result_type;

   typedef struct {
      logic [31:0] value;
      logic [31:0] modulus;
      bit          typed;       // expected result given in the row
      logic [31:0] inverse;
      logic        no_inverse;
   } pair_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_value = '0;
   logic [31:0] req_modulus = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_inverse;
   logic        rsp_no_inverse;

   inv_result_type expected_q[$];
   int             fail_count = 0;
   bit             stim_done = 1'b0;
   bit             hold_off = 1'b0;
   bit             quiet = 1'b0;

   modular_inverse_ext_euclid dut (.*);

   always #5 clock = ~clock;

   // Extended Euclid on coefficient magnitudes; signs alternate per step.
   function automatic inv_result_type predict_inverse(logic [31:0] a_in, logic [31:0] m_in);
      inv_result_type res;
      logic [63:0] m, a, r0, r1, x0, x1, q, t;
      int unsigned steps;
      m = {32'd0, m_in};
      a = {32'd0, a_in};
      res.inverse = '0;
      res.no_inverse = 1'b1;
      steps = 0;
      if (m < 2) return res;
      a = a % m;
      if (a == 0) return res;
      r0 = m; r1 = a; x0 = 0; x1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         t = r0 - q * r1;
         r0 = r1; r1 = t;
         t = x0 + q * x1;
         x0 = x1; x1 = t;
         steps++;
      end
      if (r0 != 1) return res;
      if (steps[0]) t = x0 % m;
      else t = (m - (x0 % m)) % m;
      if (t == 0) return res;
      res.inverse = t[31:0];
      res.no_inverse = 1'b0;
      return res;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 20);
         2: return $urandom & 32'h0000_FFFF;
         3: return $urandom & 32'h0000_00FF;
         default: return $urandom;
      endcase
   endfunction

   // valid stays high into the next beat unless the sender idles
   task automatic send_pair(logic [31:0] v, logic [31:0] m);
      while (!quiet && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_modulus <= m;
      do @(posedge clock); while (req_stall);
      expected_q = {expected_q, predict_inverse(v, m)};
      @(negedge clock);
   endtask

   pair_row_type directed[] = '{
      '{32'd3, 32'd0, 1'b1, 32'd0, 1'b1},
      '{32'd3, 32'd1, 1'b1, 32'd0, 1'b1},
      '{32'd0, 32'd7, 1'b1, 32'd0, 1'b1},
      '{32'd14, 32'd7, 1'b1, 32'd0, 1'b1},
      '{32'd6, 32'd9, 1'b1, 32'd0, 1'b1},
      '{32'd1, 32'd2, 1'b1, 32'd1, 1'b0},
      '{32'd3, 32'd2, 1'b1, 32'd1, 1'b0},
      '{32'd1, 32'hFFFF_FFFF, 1'b1, 32'd1, 1'b0},
      '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 1'b0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1},
      '{32'd0, 32'd0, 1'b1, 32'd0, 1'b1},
      '{32'hFFFF_FFFF, 32'd0, 1'b1, 32'd0, 1'b1},
      '{32'd3, 32'd7, 1'b0, 32'd0, 1'b0},
      '{32'd10, 32'd7, 1'b0, 32'd0, 1'b0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 32'd0, 1'b0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'd0, 1'b0},
      '{32'h5555_5555, 32'hAAAA_AAAB, 1'b0, 32'd0, 1'b0},
      '{32'hB520_1E7D, 32'hB504_F333, 1'b0, 32'd0, 1'b0},
      '{32'd2_971_215_073, 32'd1_836_311_903, 1'b0, 32'd0, 1'b0},
      '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd0, 1'b0}
   };

   // stimulus
   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) begin
         if (directed[i].typed) begin
            inv_result_type p;
            p = predict_inverse(directed[i].value, directed[i].modulus);
            if (p.inverse !== directed[i].inverse || p.no_inverse !== directed[i].no_inverse)
               $error("row %0d: predictor disagrees with table", i);
         end
         send_pair(directed[i].value, directed[i].modulus);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         quiet = (n >= 300 && n < 450);
         hold_off = (n >= 600 && n < 604);
         if ($urandom_range(0, 3) == 0)
            send_pair(rand_word(), $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom | 1);
         else
            send_pair(rand_word(), rand_word());
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stall, with one long hold-off
   initial begin
      int hold_cycles;
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            for (hold_cycles = 0; hold_cycles < 3000; hold_cycles++) @(negedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 36);
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("unexpected rsp beat: inverse %0d no_inverse %0b",
                   rsp_inverse, rsp_no_inverse);
            fail_count++;
         end else begin
            inv_result_type e;
            e = expected_q.pop_front();
            if (rsp_inverse !== e.inverse) begin
               $error("inverse: expected %0d, got %0d", e.inverse, rsp_inverse);
               fail_count++;
            end
            if (rsp_no_inverse !== e.no_inverse) begin
               $error("no_inverse: expected %0b, got %0b", e.no_inverse, rsp_no_inverse);
               fail_count++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      wait (expected_q.size() == 0);
      repeat (4000) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("modular_inverse_ext_euclid test passed");
      else
         $display("modular_inverse_ext_euclid test failed");
      $finish;
   end

   initial begin
      #200ms;
      $display("modular_inverse_ext_euclid test failed");
      $finish;
   end

endmodule
